FILE: design/dpts_pkg.sv
// Shared types and codes of the dynamic priority tick scheduler.
`default_nettype none

package dpts_pkg;

    // Beat widths on the two stream channels
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 3;

    // Operation codes carried in s_tuser
    typedef logic [S_TUSER_W-1:0] op_t;
    localparam op_t OP_LOAD  = 2'd0;
    localparam op_t OP_TICK  = 2'd1;
    localparam op_t OP_CLEAR = 2'd2;

    // Result status codes carried in m_tuser
    typedef logic [M_TUSER_W-1:0] status_t;
    localparam status_t ST_LOADED  = 3'd0;
    localparam status_t ST_FULL    = 3'd1;
    localparam status_t ST_RAN     = 3'd2;
    localparam status_t ST_IDLE    = 3'd3;
    localparam status_t ST_CLEARED = 3'd4;

    // One task table row; priority only ever decreases from its 8-bit start
    typedef struct packed {
        logic [15:0] submit;
        logic [7:0]  prio;
        logic [15:0] arrival;
        logic [15:0] remaining;
    } entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take;    // input beat accepted this cycle
        logic scan;    // table scan in progress
        logic commit;  // apply the item and load the result beat
    } dpts_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_done;  // last table row is being compared
        logic out_free;   // result register can take a beat
    } dpts_sts_t;

endpackage

`default_nettype wire

FILE: design/dpts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dpts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: design/dpts_ctrl.sv
// Controller state machine of the tick scheduler: accept, scan, commit.
`default_nettype none

module dpts_ctrl import dpts_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    input  wire op_t       s_op,
    output logic           s_tready,
    input  wire dpts_sts_t sts,
    output dpts_cmd_t      cmd
);

    typedef enum logic [2:0] {
        CS_IDLE   = 3'b001,
        CS_SCAN   = 3'b010,
        CS_COMMIT = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        take;

    // Take no beat while reset is held
    assign s_tready   = (state_reg == CS_IDLE) && aresetn;
    assign take       = s_tvalid && s_tready;
    assign cmd.take   = take;
    assign cmd.scan   = (state_reg == CS_SCAN);
    assign cmd.commit = (state_reg == CS_COMMIT) && sts.out_free;

    // Dispatch on the operation, wait for the scan, then for the result slot
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE: begin
                if (take) begin
                    case (s_op)
                        OP_TICK:  state_next = CS_SCAN;
                        OP_LOAD:  state_next = CS_COMMIT;
                        OP_CLEAR: state_next = CS_COMMIT;
                        default:  state_next = CS_IDLE;
                    endcase
                end
            end
            CS_SCAN: begin
                if (sts.scan_done) begin
                    state_next = CS_COMMIT;
                end
            end
            CS_COMMIT: begin
                if (sts.out_free) begin
                    state_next = CS_IDLE;
                end
            end
            default: state_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/dpts_datapath.sv
// Datapath of the tick scheduler: task table, best-task scan, commit and result register.
`default_nettype none

module dpts_datapath import dpts_pkg::*; #(
    parameter int MAX_PROCS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire dpts_cmd_t            cmd,
    output dpts_sts_t                 sts,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic      [M_TUSER_W-1:0] m_tuser
);

    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_PROCS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_PROCS);

    // Latched input item
    op_t         op_reg;
    logic [15:0] rt_reg;
    logic [15:0] arr_in_reg;
    logic [7:0]  prio_in_reg;

    // Scheduler state
    logic [CW-1:0]        task_count_reg, task_count_next;
    logic [CW-1:0]        done_count_reg, done_count_next;
    logic [15:0]          tick_reg, tick_next;
    logic [MAX_PROCS-1:0] complete_reg;

    // Scan pipeline
    logic [IW-1:0] scan_addr_reg;
    logic          issue_reg;
    logic          cmp_vld_reg;
    logic [IW-1:0] cmp_idx_reg;
    logic          found_reg;
    logic [IW-1:0] best_idx_reg;
    entry_t        best_reg;

    // Result register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    status_t              m_tuser_reg;

    // Table RAM
    entry_t        rd_entry;
    entry_t        wr_entry;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;

    // Commit combinational values
    logic          table_full;
    logic [15:0]   rem_dec;
    logic [7:0]    prio_dec;
    logic          fin;
    logic [CW-1:0] best_id;
    status_t       res_status;
    logic [4:0]    res_id;
    logic          res_fin;
    logic [15:0]   res_turn;
    logic          res_all_done;

    // Scan candidate check
    logic cand_ready;
    logic cand_better;

    dpts_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_PROCS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .raddr (scan_addr_reg),
        .rdata (rd_entry)
    );

    // Hold the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            op_reg      <= s_tuser;
            rt_reg      <= s_tdata[15:0];
            arr_in_reg  <= s_tdata[31:16];
            prio_in_reg <= s_tdata[39:32];
        end
    end

    // Compare the row read last cycle against the best so far
    assign cand_ready  = cmp_vld_reg && (CW'(cmp_idx_reg) < task_count_reg)
                         && !complete_reg[cmp_idx_reg] && (rd_entry.arrival <= tick_reg);
    assign cand_better = !found_reg || (rd_entry.prio > best_reg.prio)
                         || ((rd_entry.prio == best_reg.prio)
                             && (rd_entry.submit < best_reg.submit));

    assign sts.scan_done = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    // Advance the read address and keep the best ready row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg   <= 1'b0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else if (cmd.take) begin
            issue_reg   <= 1'b1;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else if (cmd.scan) begin
            cmp_vld_reg <= issue_reg;
            if (issue_reg && (scan_addr_reg == LAST_IDX)) begin
                issue_reg <= 1'b0;
            end
            if (cand_ready && cand_better) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            scan_addr_reg <= '0;
        end else if (cmd.scan) begin
            cmp_idx_reg <= scan_addr_reg;
            if (issue_reg && (scan_addr_reg != LAST_IDX)) begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
            if (cand_ready && cand_better) begin
                best_idx_reg <= cmp_idx_reg;
                best_reg     <= rd_entry;
            end
        end
    end

    // Work out the item's effect and its result
    assign table_full = (task_count_reg >= FULL_CNT);
    assign rem_dec    = best_reg.remaining - 16'd1;
    assign prio_dec   = (best_reg.prio == 8'd0) ? 8'd0 : best_reg.prio - 8'd1;
    assign fin        = (rem_dec == 16'd0);
    assign best_id    = CW'(best_idx_reg) + CW'(1);

    always_comb begin
        task_count_next = task_count_reg;
        done_count_next = done_count_reg;
        tick_next       = tick_reg;
        res_status      = ST_IDLE;
        res_id          = 5'd0;
        res_fin         = 1'b0;
        res_turn        = 16'd0;
        ram_we          = 1'b0;
        ram_waddr       = best_idx_reg;
        wr_entry.remaining = rem_dec;
        wr_entry.arrival   = best_reg.arrival;
        wr_entry.prio      = prio_dec;
        wr_entry.submit    = fin ? best_reg.submit : tick_next;
        case (op_reg)
            OP_LOAD: begin
                if (table_full) begin
                    res_status = ST_FULL;
                end else begin
                    task_count_next    = task_count_reg + 1'b1;
                    res_status         = ST_LOADED;
                    res_id             = 5'(task_count_next);
                    ram_we             = 1'b1;
                    ram_waddr          = task_count_reg[IW-1:0];
                    wr_entry.remaining = (rt_reg == 16'd0) ? 16'd1 : rt_reg;
                    wr_entry.arrival   = arr_in_reg;
                    wr_entry.prio      = prio_in_reg;
                    wr_entry.submit    = arr_in_reg;
                end
            end
            OP_TICK: begin
                tick_next       = tick_reg + 16'd1;
                wr_entry.submit = fin ? best_reg.submit : tick_next;
                if (found_reg) begin
                    res_status = ST_RAN;
                    res_id     = 5'(best_id);
                    ram_we     = 1'b1;
                    if (fin) begin
                        done_count_next = done_count_reg + 1'b1;
                        res_fin         = 1'b1;
                        res_turn        = tick_next - best_reg.arrival;
                    end
                end
            end
            OP_CLEAR: begin
                task_count_next = '0;
                done_count_next = '0;
                tick_next       = 16'd0;
                res_status      = ST_CLEARED;
            end
            default: begin
                res_status = ST_IDLE;
            end
        endcase
        ram_we       = ram_we && cmd.commit;
        res_all_done = (done_count_next == task_count_next);
    end

    // Apply the item to the scheduler state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            task_count_reg <= '0;
            done_count_reg <= '0;
            tick_reg       <= 16'd0;
            complete_reg   <= '0;
        end else if (cmd.commit) begin
            task_count_reg <= task_count_next;
            done_count_reg <= done_count_next;
            tick_reg       <= tick_next;
            if (op_reg == OP_CLEAR) begin
                complete_reg <= '0;
            end else if ((op_reg == OP_LOAD) && !table_full) begin
                complete_reg[task_count_reg[IW-1:0]] <= 1'b0;
            end else if ((op_reg == OP_TICK) && found_reg && fin) begin
                complete_reg[best_idx_reg] <= 1'b1;
            end
        end
    end

    // Load the result beat, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tuser_reg <= res_status;
            m_tdata_reg <= {1'b0, res_all_done, res_turn, tick_next, res_fin, res_id};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

FILE: design/dynamic_priority_tick_scheduler.sv
// Top level of the dynamic priority tick scheduler.
//
// Input beats carry an operation in s_tuser: load a task, run one time tick,
// or clear the table and time. Every load, tick and clear gives exactly one
// result beat; operation code 3 is taken and dropped without a result.
// A loaded task gets id = load order + 1. A tick runs one unit of the ready
// task with the highest priority (then earliest submit time, then lowest id),
// ages its priority by one (not below zero) and advances time by one.
// A load or clear goes from the input beat to the commit state, which loads
// the result register and raises m_tvalid; the next beat is taken once the
// block is back in idle. A tick first runs the scan, which reads one task
// table row per cycle from the single-read-port table RAM, then commits.
// The result register parts the channels: while m_tready is low the block
// still takes and works the next item and then holds until the slot frees.
// Reset (aresetn low, synchronous) empties the table, zeroes time and the
// counters and drops any pending result; no clearing pass is needed.
`default_nettype none

module dynamic_priority_tick_scheduler import dpts_pkg::*; #(
    parameter int MAX_PROCS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // run_time[15:0], arrival_time[31:16], start_priority[39:32]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // operation[1:0]
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // task_id[4:0], task_finished[5], finish_time[21:6], turnaround[37:22],
    // all_done[38], zero pad[39]
    output logic      [M_TDATA_W-1:0] m_tdata,
    // status[2:0]
    output logic      [M_TUSER_W-1:0] m_tuser
);

    dpts_cmd_t cmd;
    dpts_sts_t sts;

    dpts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dpts_datapath #(
        .MAX_PROCS (MAX_PROCS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Commit only into a free result slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> sts.out_free)
        else $error("commit while result slot is occupied");

    // A result beat appears only after a commit
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.commit))
        else $error("result beat without commit");

    // No new item is taken while a scan runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && cmd.scan))
        else $error("input ready during scan");

    // Scan and commit never overlap
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.scan && cmd.commit))
        else $error("scan and commit in the same cycle");

endmodule

`default_nettype wire
